/* rtl/assert_macros.svh */
// Assertion macros shared by the capture record deframer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/crd_pkg.sv */
// Shared types and constants for the capture record deframer.
// No dependencies; imported by the divider, parser, output stage and top level.
`timescale 1ns / 1ps
`default_nettype none

package crd_pkg;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [31:0] NS_PER_SEC_X2 = 32'd2000000000;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Divider control from the parser.
    typedef struct packed {
        logic clear;
        logic step;
    } div_ctrl_t;

    // One result word.
    typedef struct packed {
        logic        item_kind;
        logic [31:0] ts_seconds;
        logic [29:0] ts_nanoseconds;
        logic [15:0] record_length;
        logic [7:0]  payload_byte;
        logic        last_of_record;
    } crd_result_t;

endpackage

`default_nettype wire

/* rtl/capture_record_deframer_top.sv */
// Result words are registered in the output register or the skid entry before output.
// Throughput: one byte per cycle while the skid entry is empty; the timestamp divider
// resolves one quotient digit per timestamp byte, so the header is ready when the last
// length byte arrives. A word made during an output stall waits in the skid entry;
// input then pauses until the cycle after the output takes a word.
// Reset: rst_n clears parser phase, counters, divider and output valid flags
// asynchronously; the block then hunts for a marker.
`timescale 1ns / 1ps
`default_nettype none

module capture_record_deframer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tuser,  // [0] buffer_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata,  // [31:0] ts_seconds, [61:32] ts_nanoseconds,
                                            // [77:62] record_length, [85:78] payload_byte
    output logic             m_axis_tuser,  // [0] item_kind
    output logic             m_axis_tlast   // last_of_record
);
    import crd_pkg::*;

    logic        in_fire;
    logic        res_valid;
    crd_result_t res;
    crd_result_t out_res;
    logic        stage_ready;

    assign s_axis_tready = stage_ready;
    assign in_fire       = s_axis_tvalid && stage_ready;

    crd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .data_byte    (s_axis_tdata),
        .buffer_start (s_axis_tuser),
        .res_valid    (res_valid),
        .res          (res)
    );

    crd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (stage_ready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, out_res.payload_byte, out_res.record_length,
                           out_res.ts_nanoseconds, out_res.ts_seconds};
    assign m_axis_tuser = out_res.item_kind;
    assign m_axis_tlast = out_res.last_of_record;

endmodule

`default_nettype wire

/* rtl/crd_ts_divider.sv */
// Byte-serial division of the big-endian timestamp by one billion.
// One quotient digit per timestamp byte; depends on crd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crd_ts_divider (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crd_pkg::div_ctrl_t ctrl,
    input  wire logic [7:0]        data_byte,
    output logic [31:0]            quot,
    output logic [29:0]            rem
);
    import crd_pkg::*;

    typedef logic [7:0]  seed_tbl_t [256];
    typedef logic [37:0] prod_tbl_t [256];

    // Digit estimate from the top eight bits of the partial dividend.
    function automatic seed_tbl_t build_seed_tbl();
        seed_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 8'((64'(i) << 30) / 64'(NS_PER_SEC));
        end
        return t;
    endfunction

    function automatic prod_tbl_t build_prod_tbl();
        prod_tbl_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 38'(64'(8'((64'(i) << 30) / 64'(NS_PER_SEC))) * 64'(NS_PER_SEC));
        end
        return t;
    endfunction

    localparam seed_tbl_t SEED_TBL = build_seed_tbl();
    localparam prod_tbl_t PROD_TBL = build_prod_tbl();

    logic [31:0] quot_reg, quot_next;
    logic [29:0] rem_reg, rem_next;
    logic [37:0] partial;
    logic [37:0] diff;
    logic [31:0] diff_lo;
    logic [7:0]  digit;
    logic [7:0]  seed;
    logic [29:0] rem_step;

    always_comb
    begin
        partial = {rem_reg, data_byte};
        seed    = SEED_TBL[rem_reg[29:22]];
        diff    = partial - PROD_TBL[rem_reg[29:22]];
        // estimate is low by at most two
        diff_lo = diff[31:0];
        if (diff_lo >= NS_PER_SEC_X2)
        begin
            digit    = seed + 8'd2;
            rem_step = 30'(diff_lo - NS_PER_SEC_X2);
        end
        else if (diff_lo >= {2'b00, NS_PER_SEC})
        begin
            digit    = seed + 8'd1;
            rem_step = 30'(diff_lo - {2'b00, NS_PER_SEC});
        end
        else
        begin
            digit    = seed;
            rem_step = diff_lo[29:0];
        end

        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (ctrl.clear)
        begin
            quot_next = '0;
            rem_next  = '0;
        end
        else if (ctrl.step)
        begin
            quot_next = {quot_reg[23:0], digit};
            rem_next  = rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* rtl/crd_parser.sv */
// Record parser: marker hunt, header assembly, payload count.
// Depends on crd_pkg, crd_ts_divider and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crd_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic [7:0]          data_byte,
    input  wire logic                buffer_start,
    output logic                     res_valid,
    output crd_pkg::crd_result_t     res
);
    import crd_pkg::*;

    localparam logic [7:0] MARK_BYTE  = 8'hEE;
    localparam logic [2:0] TS_LAST    = 3'd7;

    typedef enum logic [3:0] {
        PH_HUNT = 4'b0001,
        PH_TIME = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_LOAD = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    phase_t      phase_eff;
    logic [2:0]  count_reg, count_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] length_full;
    div_ctrl_t   div_ctrl;
    logic [31:0] div_quot;
    logic [29:0] div_rem;

    crd_ts_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .data_byte (data_byte),
        .quot      (div_quot),
        .rem       (div_rem)
    );

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        len_hi_next    = len_hi_reg;
        remaining_next = remaining_reg;
        div_ctrl       = '0;
        res_valid      = 1'b0;
        res            = '0;
        length_full    = {len_hi_reg, data_byte};
        // a buffer start drops any record in progress
        phase_eff      = buffer_start ? PH_HUNT : phase_reg;

        if (in_fire)
        begin
            case (phase_eff)
                PH_HUNT:
                begin
                    phase_next = PH_HUNT;
                    if (data_byte == MARK_BYTE)
                    begin
                        phase_next     = PH_TIME;
                        count_next     = '0;
                        div_ctrl.clear = 1'b1;
                    end
                end
                PH_TIME:
                begin
                    div_ctrl.step = 1'b1;
                    count_next    = count_reg + 3'd1;
                    if (count_reg == TS_LAST)
                    begin
                        phase_next = PH_LEN;
                        count_next = '0;
                    end
                end
                PH_LEN:
                begin
                    if (count_reg == 3'd0)
                    begin
                        len_hi_next = data_byte;
                        count_next  = 3'd1;
                    end
                    else
                    begin
                        count_next         = '0;
                        res_valid          = 1'b1;
                        res.item_kind      = KIND_HEADER;
                        res.ts_seconds     = div_quot;
                        res.ts_nanoseconds = div_rem;
                        res.record_length  = length_full;
                        res.last_of_record = (length_full == 16'd0);
                        remaining_next     = length_full;
                        phase_next         = (length_full == 16'd0) ? PH_HUNT : PH_LOAD;
                    end
                end
                PH_LOAD:
                begin
                    res_valid        = 1'b1;
                    res.item_kind    = KIND_PAYLOAD;
                    res.payload_byte = data_byte;
                    remaining_next   = remaining_reg - 16'd1;
                    if (remaining_reg == 16'd1)
                    begin
                        res.last_of_record = 1'b1;
                        phase_next         = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_hi_reg <= len_hi_next;
    end

    `ASSERT_CLK_RST(a_load_nonzero, clk, rst_n,
        (phase_reg == PH_LOAD) |-> (remaining_reg != 16'd0),
        "payload phase with nothing left to pass")

    `ASSERT_CLK_RST(a_rem_range, clk, rst_n,
        div_rem < NS_PER_SEC,
        "timestamp remainder out of range")

    `ASSERT_CLK_RST(a_header_to_load, clk, rst_n,
        (res_valid && (res.item_kind == KIND_HEADER) && !res.last_of_record)
            |=> (phase_reg == PH_LOAD),
        "header with payload not followed by payload phase")

endmodule

`default_nettype wire

/* rtl/crd_out_skid.sv */
// Output register with a skid entry between the parser and the result port.
// Depends on crd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crd_out_skid (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire crd_pkg::crd_result_t in_data,
    output logic                      in_ready,
    output logic                      out_valid,
    output crd_pkg::crd_result_t      out_data,
    input  wire logic                 out_ready
);
    import crd_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    crd_result_t main_reg, main_next;
    crd_result_t skid_reg, skid_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = in_valid;
            end
        end
        else if (in_valid)
        begin
            // hold the new word aside while the output stalls
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    `ASSERT_CLK_RST(a_skid_behind_main, clk, rst_n,
        skid_valid_reg |-> main_valid_reg,
        "skid entry filled while output register empty")

    `ASSERT_CLK_RST(a_no_push_when_full, clk, rst_n,
        skid_valid_reg |-> !in_valid,
        "word pushed while skid entry occupied")

    `ASSERT_CLK_RST(a_stall_fills_skid, clk, rst_n,
        (main_valid_reg && !out_ready && in_valid) |=> skid_valid_reg,
        "word lost during output stall")

endmodule

`default_nettype wire
